// ===== rtl/sfs_pkg.sv =====
`default_nettype none

package sfs_pkg;

   localparam int TIME_W  = 64;
   localparam int LEN_W   = 36;
   localparam int DUR_W   = 32;
   localparam int COORD_W = 12;
   localparam int DIV_CNT_W = 6;

   localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

   typedef enum logic [1:0] {
      FUNC_OPEN   = 2'd0,
      FUNC_APPEND = 2'd1,
      FUNC_LOOKUP = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_ANIM_FULL  = 2'd1,
      STATUS_FRAME_FULL = 2'd2,
      STATUS_NO_ANIM    = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_APPEND,
      ST_LK_CHECK,
      ST_DIV,
      ST_SCAN,
      ST_EXP_SUB,
      ST_EXP_ADD,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic [1:0]         func;
      logic [DUR_W-1:0]   frame_duration;
      logic [COORD_W-1:0] src_x;
      logic [COORD_W-1:0] src_y;
      logic [COORD_W-1:0] src_w;
      logic [COORD_W-1:0] src_h;
      logic [3:0]         anim_index;
      logic [TIME_W-1:0]  phase_shift;
      logic [TIME_W-1:0]  time_now;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [3:0]         frame_index;
      logic [COORD_W-1:0] frame_x;
      logic [COORD_W-1:0] frame_y;
      logic [COORD_W-1:0] frame_w;
      logic [COORD_W-1:0] frame_h;
      logic [TIME_W-1:0]  expire_time;
      logic [LEN_W-1:0]   anim_length;
   } rsp_type;

   typedef struct packed {
      logic [LEN_W-1:0]   cum;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] w;
      logic [COORD_W-1:0] h;
   } frame_entry_type;

   typedef struct packed {
      logic [TIME_W-1:0] a;
      logic [TIME_W-1:0] b;
      logic              sub;
   } alu_op_type;

endpackage

`default_nettype wire

// ===== rtl/sprite_animation_frame_sequencer_core.sv =====
`default_nettype none

// Sprite animation frame sequencer.
// Input channel (req_*): one item per command. func selects open a new
// animation, append a frame to the newest animation, or look up the frame
// that is current at time_now for animation anim_index.
// Result channel (rsp_*): exactly one item per input item, carrying a status
// and, after a successful lookup, the frame number, its rectangle, the time
// at which it expires and the animation's total length.
// Flow: open and unused commands go from decode straight to the result
// register; an append adds an append step, a lookup a check step. A good
// lookup then runs a 64-step restoring division (one quotient bit per cycle
// through the shared adder), a scan of one frame per cycle through the frame
// memory read port, then a subtract and an add to form the expiry time.
// req_stall stays high while an item is in work; one item is in work at a
// time and the next one is taken the cycle after the result register loads.
// A finished result sits in the output register, so the next item is taken
// while that result waits. While rsp_stall is high the result holds and a
// finished item waits in the sequencer.
// Reset (synchronous, active high) empties the animation table; the frame
// memory needs no clearing since only written frames are ever read.

module sprite_animation_frame_sequencer_core
   import sfs_pkg::*;
#(
   parameter int MAX_ANIMS  = 16,
   parameter int MAX_FRAMES = 16
)(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_stall,
   input  req_type   req_data,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   output rsp_type   rsp_data
);

   localparam int CW  = $clog2(MAX_ANIMS + 1);
   localparam int AW  = (MAX_ANIMS > 1) ? $clog2(MAX_ANIMS) : 1;
   localparam int NW  = $clog2(MAX_FRAMES + 1);
   localparam int FIW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int FM_DEPTH = MAX_ANIMS * MAX_FRAMES;
   localparam int FAW = (FM_DEPTH > 1) ? $clog2(FM_DEPTH) : 1;

   // control state
   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [NW-1:0]        cur_frames_ff, cur_frames_in;
   logic [LEN_W-1:0]     cur_total_ff, cur_total_in;
   logic [MAX_ANIMS-1:0] anim_vld_ff;
   logic                 rsp_valid_ff, rsp_valid_in;

   // item datapath
   req_type              req_ff, req_in;
   logic [1:0]           status_ff, status_in;
   logic [LEN_W-1:0]     rem_ff, rem_in;
   logic [TIME_W-1:0]    dvd_ff, dvd_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [FIW-1:0]       f_ff, f_in;
   logic [TIME_W-1:0]    acc_ff, acc_in;
   rsp_type              rsp_ff, rsp_next;

   // animation table
   logic [NW-1:0]        anim_frames_mem_ff [MAX_ANIMS];
   logic [LEN_W-1:0]     anim_total_mem_ff [MAX_ANIMS];
   logic [NW-1:0]        anim_frames_rd_ff;
   logic [LEN_W-1:0]     anim_total_rd_ff;

   logic                 anim_wr_en;
   logic                 fm_wr_en;
   logic                 rsp_load;
   logic [FAW-1:0]       fm_wr_addr, fm_rd_addr;
   frame_entry_type      fm_wr_data, fm_rd_data;

   alu_op_type           alu_op;
   logic [TIME_W-1:0]    alu_sum;
   logic                 alu_carry;

   logic [CW-1:0]        newest_c;
   logic [AW-1:0]        newest_a;
   logic [AW+3:0]        lk_wide;
   logic [AW-1:0]        lk_a;
   logic                 lk_in_range;
   logic [LEN_W:0]       div_trial;
   logic [LEN_W-1:0]     app_sum;
   logic [NW-1:0]        f_plus;
   logic [FIW+3:0]       fi_wide;

   // --------------------------------------------------------------------
   // Address and index helpers
   // --------------------------------------------------------------------
   assign newest_c = count_ff - CW'(1);
   assign newest_a = newest_c[AW-1:0];

   // anim_index is 4 bits; fold it to the table's index width
   assign lk_wide     = {{AW{1'b0}}, req_ff.anim_index};
   assign lk_a        = lk_wide[AW-1:0];
   assign lk_in_range = ({{CW{1'b0}}, req_ff.anim_index} < {4'b0000, count_ff});

   assign div_trial = {rem_ff, dvd_ff[TIME_W-1]};
   assign f_plus    = NW'(f_ff) + NW'(1);
   assign fi_wide   = {4'b0000, f_ff};

   // saturate the running total at the largest 36-bit length
   assign app_sum = alu_sum[LEN_W] ? LEN_MAX : alu_sum[LEN_W-1:0];

   assign fm_wr_addr = FAW'(32'(newest_a) * 32'(MAX_FRAMES) + 32'(cur_frames_ff));
   // read the frame that the scan will look at in the next cycle
   assign fm_rd_addr = FAW'(32'(lk_a) * 32'(MAX_FRAMES) + 32'(f_in));

   assign fm_wr_data.cum = app_sum;
   assign fm_wr_data.x   = req_ff.src_x;
   assign fm_wr_data.y   = req_ff.src_y;
   assign fm_wr_data.w   = req_ff.src_w;
   assign fm_wr_data.h   = req_ff.src_h;

   // --------------------------------------------------------------------
   // Shared adder: one add or subtract per cycle, picked by state
   // --------------------------------------------------------------------
   always_comb begin
      alu_op = '0;
      case (state_ff)
         ST_DECODE: begin
            alu_op.a   = req_ff.time_now;
            alu_op.b   = req_ff.phase_shift;
            alu_op.sub = 1'b1;
         end
         ST_APPEND: begin
            alu_op.a   = TIME_W'(cur_total_ff);
            alu_op.b   = TIME_W'(req_ff.frame_duration);
            alu_op.sub = 1'b0;
         end
         ST_DIV: begin
            alu_op.a   = TIME_W'(div_trial);
            alu_op.b   = TIME_W'(anim_total_rd_ff);
            alu_op.sub = 1'b1;
         end
         ST_SCAN: begin
            alu_op.a   = TIME_W'(rem_ff);
            alu_op.b   = TIME_W'(fm_rd_data.cum);
            alu_op.sub = 1'b1;
         end
         ST_EXP_SUB: begin
            alu_op.a   = req_ff.time_now;
            alu_op.b   = TIME_W'(rem_ff);
            alu_op.sub = 1'b1;
         end
         ST_EXP_ADD: begin
            alu_op.a   = acc_ff;
            alu_op.b   = TIME_W'(fm_rd_data.cum);
            alu_op.sub = 1'b0;
         end
         default: begin
            alu_op = '0;
         end
      endcase
   end

   sfs_alu u_alu (
      .op    (alu_op),
      .sum   (alu_sum),
      .carry (alu_carry)
   );

   sfs_frame_mem #(
      .DEPTH  (FM_DEPTH),
      .ADDR_W (FAW)
   ) u_frame_mem (
      .clock   (clock),
      .wr_en   (fm_wr_en),
      .wr_addr (fm_wr_addr),
      .wr_data (fm_wr_data),
      .rd_addr (fm_rd_addr),
      .rd_data (fm_rd_data)
   );

   // --------------------------------------------------------------------
   // Sequencer: next state and datapath updates
   // --------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      count_in      = count_ff;
      cur_frames_in = cur_frames_ff;
      cur_total_in  = cur_total_ff;
      status_in     = status_ff;
      rem_in        = rem_ff;
      dvd_in        = dvd_ff;
      cnt_in        = cnt_ff;
      f_in          = f_ff;
      acc_in        = acc_ff;
      anim_wr_en    = 1'b0;
      fm_wr_en      = 1'b0;
      rsp_load      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            status_in = STATUS_OK;
            state_in  = ST_RESULT;
            case (req_ff.func)
               FUNC_OPEN: begin
                  if (count_ff >= CW'(MAX_ANIMS)) begin
                     status_in = STATUS_ANIM_FULL;
                  end else begin
                     // a fresh animation starts empty
                     count_in      = count_ff + CW'(1);
                     cur_frames_in = '0;
                     cur_total_in  = '0;
                  end
               end
               FUNC_APPEND: begin
                  if (count_ff == '0) begin
                     status_in = STATUS_NO_ANIM;
                  end else if (cur_frames_ff >= NW'(MAX_FRAMES)) begin
                     status_in = STATUS_FRAME_FULL;
                  end else begin
                     state_in = ST_APPEND;
                  end
               end
               FUNC_LOOKUP: begin
                  // dividend = time_now - phase_shift, wrapping
                  dvd_in   = alu_sum;
                  rem_in   = '0;
                  cnt_in   = '0;
                  f_in     = '0;
                  state_in = ST_LK_CHECK;
               end
               default: begin
                  state_in = ST_RESULT;
               end
            endcase
         end

         ST_APPEND: begin
            fm_wr_en      = 1'b1;
            anim_wr_en    = 1'b1;
            cur_total_in  = app_sum;
            cur_frames_in = cur_frames_ff + NW'(1);
            state_in      = ST_RESULT;
         end

         ST_LK_CHECK: begin
            if (!lk_in_range || !anim_vld_ff[lk_a] || (anim_total_rd_ff == '0)) begin
               status_in = STATUS_NO_ANIM;
               state_in  = ST_RESULT;
            end else begin
               state_in = ST_DIV;
            end
         end

         ST_DIV: begin
            // restoring step: keep the difference when no borrow
            rem_in = alu_carry ? alu_sum[LEN_W-1:0] : div_trial[LEN_W-1:0];
            dvd_in = {dvd_ff[TIME_W-2:0], 1'b0};
            cnt_in = cnt_ff + DIV_CNT_W'(1);
            f_in   = '0;
            if (cnt_ff == DIV_CNT_W'(TIME_W - 1)) begin
               state_in = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // advance while this frame already ended and a later one exists
            if (alu_carry && (f_plus < anim_frames_rd_ff)) begin
               f_in = f_ff + FIW'(1);
            end else begin
               state_in = ST_EXP_SUB;
            end
         end

         ST_EXP_SUB: begin
            acc_in   = alu_sum;
            state_in = ST_EXP_ADD;
         end

         ST_EXP_ADD: begin
            acc_in   = alu_sum;
            state_in = ST_RESULT;
         end

         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // --------------------------------------------------------------------
   // Result assembly: fields carry values only after a good lookup
   // --------------------------------------------------------------------
   always_comb begin
      rsp_next        = '0;
      rsp_next.status = status_ff;
      if ((req_ff.func == FUNC_LOOKUP) && (status_ff == STATUS_OK)) begin
         rsp_next.frame_index = fi_wide[3:0];
         rsp_next.frame_x     = fm_rd_data.x;
         rsp_next.frame_y     = fm_rd_data.y;
         rsp_next.frame_w     = fm_rd_data.w;
         rsp_next.frame_h     = fm_rd_data.h;
         rsp_next.expire_time = acc_ff;
         rsp_next.anim_length = anim_total_rd_ff;
      end
   end

   // hold the result until taken
   assign rsp_valid_in = rsp_load | (rsp_valid_ff & rsp_stall);

   // --------------------------------------------------------------------
   // Registers
   // --------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         cur_frames_ff <= '0;
         cur_total_ff  <= '0;
         anim_vld_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         cur_frames_ff <= cur_frames_in;
         cur_total_ff  <= cur_total_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (anim_wr_en) begin
            anim_vld_ff[newest_a] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      status_ff <= status_in;
      rem_ff    <= rem_in;
      dvd_ff    <= dvd_in;
      cnt_ff    <= cnt_in;
      f_ff      <= f_in;
      acc_ff    <= acc_in;
      if (rsp_load) begin
         rsp_ff <= rsp_next;
      end
   end

   // animation table: written by appends, read at the lookup index
   always_ff @(posedge clock) begin
      if (anim_wr_en) begin
         anim_frames_mem_ff[newest_a] <= cur_frames_ff + NW'(1);
         anim_total_mem_ff[newest_a]  <= app_sum;
      end
      anim_frames_rd_ff <= anim_frames_mem_ff[lk_a];
      anim_total_rd_ff  <= anim_total_mem_ff[lk_a];
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   // the partial remainder stays below the divisor through the division
   a_div_rem_below_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < anim_total_rd_ff))
      else $error("division remainder reached the animation length");

   // the scan never runs past the frames that the animation holds
   a_scan_in_frames: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (NW'(f_ff) < anim_frames_rd_ff))
      else $error("frame scan ran beyond the animation");

   // the animation count only holds or steps up by one
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ((count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + CW'(1))))
      else $error("animation count changed by more than one");

   // a good lookup always reports a nonzero length
   a_lookup_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && (req_ff.func == FUNC_LOOKUP) && (status_ff == STATUS_OK))
         |=> (rsp_ff.anim_length != '0))
      else $error("lookup result with zero animation length");
`endif

endmodule

`default_nettype wire

// ===== rtl/sfs_alu.sv =====
`default_nettype none

module sfs_alu
   import sfs_pkg::*;
(
   input  alu_op_type        op,
   output logic [TIME_W-1:0] sum,
   output logic              carry
);

   logic [TIME_W-1:0] b_eff;

   // carry high on a subtract means no borrow (a >= b)
   assign b_eff = op.sub ? ~op.b : op.b;
   assign {carry, sum} = {1'b0, op.a} + {1'b0, b_eff} + {{TIME_W{1'b0}}, op.sub};

endmodule

`default_nettype wire

// ===== rtl/sfs_frame_mem.sv =====
`default_nettype none

module sfs_frame_mem
   import sfs_pkg::*;
#(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
)(
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_W-1:0]     wr_addr,
   input  frame_entry_type            wr_data,
   input  wire logic [ADDR_W-1:0]     rd_addr,
   output frame_entry_type            rd_data
);

   frame_entry_type mem_ff [DEPTH];
   frame_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
